FILE: rtl/bssm_pkg.sv
// Shared constants and types of the barrier-synced stereo mixer.
package bssm_pkg;

  // Ring and channel sizing
  localparam int unsigned RING_DEPTH    = 256;
  localparam int unsigned CHANNEL_COUNT = 16;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CHANNEL_W = 4;

  // Derived widths
  localparam int unsigned RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W      = SAMPLE_W + $clog2(CHANNEL_COUNT);
  localparam int unsigned FRAME_W    = 2 * SAMPLE_W;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN  = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_DRAIN  = 2'd3
  } func_e;

  // Flags of one item on its way to the output register
  typedef struct packed {
    logic accepted;
    logic written;
    logic overflow;
    logic pop;
  } flags_t;

endpackage

FILE: rtl/bssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bssm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/barrier_synced_stereo_mixer_unit.sv
// Top level of the barrier-synced stereo mixer.
//
// Usage: each input word carries a function code, a channel number and a
// stereo sample. Begin and stop words enable or disable a channel. Sample
// words add into the current frame; once every active channel has given one
// sample, the frame is clamped to 16 bits and stored in the ring if not full.
// Drain words pop the oldest frame, but only after the ring has once filled.
// Every input word yields exactly one result word with the status flags and,
// for a successful drain, the popped left and right samples (zero otherwise).
//
// Timing: a word is accepted when in_valid_i is high and in_stall_o low. All
// mixer state updates at that edge; the ring read issues there too, so the
// flags and the read data wait in the middle stage and move into the output
// register once it is free or not stalled, to be taken from the result port.
// The block takes one word per cycle while in_stall_o is low; the single ring
// read port and its registered read data set the two-stage result path.
// When res_stall_i holds the result, one more word is taken into the middle
// stage; after that in_stall_o rises until the result drains.
// Reset clears channel masks, sums, ring pointers and the fill flag at once;
// the ring contents need no clearing and no item waits after reset.
module barrier_synced_stereo_mixer_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bssm_pkg::FUNC_W-1:0]            func_i,
  input  logic [bssm_pkg::CHANNEL_W-1:0]         channel_i,
  input  logic signed [bssm_pkg::SAMPLE_W-1:0]   in_left_i,
  input  logic signed [bssm_pkg::SAMPLE_W-1:0]   in_right_i,
  // Result channel
  output logic                                   res_valid_o,
  input  logic                                   res_stall_i,
  output logic                                   accepted_o,
  output logic                                   frame_written_o,
  output logic                                   overflow_o,
  output logic                                   out_valid_o,
  output logic signed [bssm_pkg::SAMPLE_W-1:0]   out_left_o,
  output logic signed [bssm_pkg::SAMPLE_W-1:0]   out_right_o
);

  import bssm_pkg::*;

  localparam logic signed [SUM_W-1:0] SatMax = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SatMin = ~SatMax;
  localparam logic [RING_IDX_W-1:0]   LastIdx = RING_IDX_W'(RING_DEPTH - 1);

  // Clamp a wide sum to the sample range
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > SatMax) begin
      c = SatMax;
    end else if (v < SatMin) begin
      c = SatMin;
    end else begin
      c = v;
    end
    return c[SAMPLE_W-1:0];
  endfunction

  // Advance a ring pointer with wrap
  function automatic logic [RING_IDX_W-1:0] next_idx(input logic [RING_IDX_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + RING_IDX_W'(1);
  endfunction

  // Mixer state
  logic [CHANNEL_COUNT-1:0]   active_q, active_d;
  logic [CHANNEL_COUNT-1:0]   contrib_q, contrib_d;
  logic signed [SUM_W-1:0]    lsum_q, lsum_d;
  logic signed [SUM_W-1:0]    rsum_q, rsum_d;
  logic [RING_IDX_W-1:0]      widx_q, widx_d;
  logic [RING_IDX_W-1:0]      ridx_q, ridx_d;
  logic                       prefilled_q, prefilled_d;

  // Result path
  logic                       s1_valid_q, s1_valid_d;
  flags_t                     s1_q, s1_d;
  logic                       res_valid_q, res_valid_d;
  flags_t                     res_q, res_d;
  logic [SAMPLE_W-1:0]        res_left_q, res_left_d;
  logic [SAMPLE_W-1:0]        res_right_q, res_right_d;

  // Ring port
  logic                       ram_we, ram_re;
  logic [FRAME_W-1:0]         ram_wdata, ram_rdata;

  // Handshake
  logic                       s1_adv;
  logic                       acc;

  // Item decode helpers
  logic                       chan_ok;
  logic [CHANNEL_COUNT-1:0]   ch_bit;
  logic                       first;
  logic [CHANNEL_COUNT-1:0]   contrib_add;
  logic signed [SUM_W-1:0]    lsum_add, rsum_add;
  logic [RING_IDX_W-1:0]      widx_next;

  assign s1_adv     = s1_valid_q && (!res_valid_q || !res_stall_i);
  assign in_stall_o = s1_valid_q && res_valid_q && res_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  // Decode channel and the first-add view of the frame
  always_comb begin
    chan_ok     = {1'b0, channel_i} < (CHANNEL_W + 1)'(CHANNEL_COUNT);
    ch_bit      = chan_ok ? (CHANNEL_COUNT'(1) << channel_i) : '0;
    first       = (contrib_q & ch_bit) == '0;
    contrib_add = first ? (contrib_q | ch_bit) : contrib_q;
    lsum_add    = first ? (lsum_q + SUM_W'(in_left_i)) : lsum_q;
    rsum_add    = first ? (rsum_q + SUM_W'(in_right_i)) : rsum_q;
    widx_next   = next_idx(widx_q);
  end

  // Read, modify and write back the mixer state
  always_comb begin
    active_d    = active_q;
    contrib_d   = contrib_q;
    lsum_d      = lsum_q;
    rsum_d      = rsum_q;
    widx_d      = widx_q;
    ridx_d      = ridx_q;
    prefilled_d = prefilled_q;
    s1_d        = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = {clamp_sample(lsum_add), clamp_sample(rsum_add)};
    if (acc) begin
      unique case (func_e'(func_i))
        FUNC_BEGIN: begin
          active_d  = active_q | ch_bit;
          contrib_d = contrib_q & ~ch_bit;
        end
        FUNC_STOP: begin
          active_d  = active_q & ~ch_bit;
          contrib_d = contrib_q & ~ch_bit;
        end
        FUNC_SAMPLE: begin
          if (chan_ok) begin
            if ((active_q & ~contrib_add) == '0) begin
              // Complete the frame, store or drop it
              s1_d.written  = 1'b1;
              s1_d.accepted = 1'b1;
              if (widx_next == ridx_q) begin
                prefilled_d   = 1'b1;
                s1_d.overflow = 1'b1;
              end else begin
                ram_we = 1'b1;
                widx_d = widx_next;
              end
              // Seed the next frame with a refused sample
              if (first) begin
                lsum_d    = '0;
                rsum_d    = '0;
                contrib_d = '0;
              end else begin
                lsum_d    = SUM_W'(in_left_i);
                rsum_d    = SUM_W'(in_right_i);
                contrib_d = ch_bit;
              end
            end else begin
              lsum_d        = lsum_add;
              rsum_d        = rsum_add;
              contrib_d     = contrib_add;
              s1_d.accepted = first;
            end
          end
        end
        FUNC_DRAIN: begin
          if (prefilled_q && (ridx_q != widx_q)) begin
            ram_re   = 1'b1;
            s1_d.pop = 1'b1;
            ridx_d   = next_idx(ridx_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Move the middle stage into the output register
  always_comb begin
    s1_valid_d  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    res_valid_d = s1_adv ? 1'b1 : (res_stall_i ? res_valid_q : 1'b0);
    res_d       = s1_adv ? s1_q : res_q;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    if (s1_adv) begin
      res_left_d  = s1_q.pop ? ram_rdata[FRAME_W-1:SAMPLE_W] : '0;
      res_right_d = s1_q.pop ? ram_rdata[SAMPLE_W-1:0] : '0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      contrib_q   <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
      widx_q      <= '0;
      ridx_q      <= '0;
      prefilled_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      contrib_q   <= contrib_d;
      lsum_q      <= lsum_d;
      rsum_q      <= rsum_d;
      widx_q      <= widx_d;
      ridx_q      <= ridx_d;
      prefilled_q <= prefilled_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    res_q       <= res_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
  end

  // Frame ring: left in the upper half, right in the lower half
  bssm_ram #(
    .Width(FRAME_W),
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ridx_q),
    .rdata_o(ram_rdata)
  );

  assign res_valid_o     = res_valid_q;
  assign accepted_o      = res_q.accepted;
  assign frame_written_o = res_q.written;
  assign overflow_o      = res_q.overflow;
  assign out_valid_o     = res_q.pop;
  assign out_left_o      = res_left_q;
  assign out_right_o     = res_right_q;

  // A stalled input always means both result stages are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && res_valid_q))
    else $error("input stalled with a free result stage");

  // An accepted pop shows up in the middle stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ram_re) |=> (s1_valid_q && s1_q.pop))
    else $error("popped frame lost before the middle stage");

  // A stored frame never leaves the ring looking empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (widx_q != ridx_q))
    else $error("ring pointers collide after a store");

  // Overflow only flags a completed frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.overflow) |-> s1_q.written)
    else $error("overflow without a completed frame");

  // A pop is never issued before the ring has once filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> prefilled_q)
    else $error("ring read before the first fill");

endmodule
